FILE: src/rdwr_pkg.sv
// shared types and constants for the random draw without replacement core
// no dependencies

package rdwr_pkg;

    localparam int VW = 8;           // stored and returned vertex width
    localparam int RW = 31;          // random word width
    localparam int CFG_AW = 2;       // configuration index width
    localparam int CFG_DW = 8;       // widest configuration register

    localparam logic [CFG_AW-1:0] CFG_FIRST_POS   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SECOND_POS  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_EXCLUDE_TWO = 2'd2;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_DRAW    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_EMIT
    } state_t;

endpackage

FILE: src/rdwr_rem.sv
// restoring remainder unit, one quotient bit per cycle
// depends on rdwr_pkg

module rdwr_rem
    import rdwr_pkg::*;
#(
    parameter int IW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [RW-1:0] dividend,
    input  logic [IW-1:0] divisor,
    output logic          done,
    output logic [IW-1:0] rem
);

    localparam int SW = $clog2(RW);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [RW-1:0] dvd_reg;
    logic [IW-1:0] rem_reg;
    logic [IW:0]   trial;
    logic [IW:0]   diff;
    logic [IW-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[RW-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[IW-1:0];
        end
        else
        begin
            rem_next = trial[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: src/rdwr_pool.sv
// pool store, one write port and one registered read port
// depends on rdwr_pkg

module rdwr_pool
    import rdwr_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [VW-1:0] rdata
);

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/random_draw_without_replacement_core.sv
// top level: sequencer, configuration registers and output register
// depends on rdwr_pkg, rdwr_rem, rdwr_pool
//
//  port group   dir  payload
//  s_*          in   tuser: operation; tdata: random_word [30:0], zero pad to 32
//  m_*          out  tuser: empty_res; tdata: vertex [7:0]
//  cfg_*        in   cfg_addr picks first_pos, second_pos, exclude_two
//
// restart: refills all VERTICES entries of the pool, one entry per cycle
// draw: the bit-serial remainder unit, then two reads and two writes of the
// pool (RD_A, RD_B, WR_A, WR_B); an empty draw goes straight to EMIT
// a new beat is taken while a finished result still waits on the m side
// reset clears live count, so draws report empty until the first restart

module random_draw_without_replacement_core
    import rdwr_pkg::*;
#(
    parameter int VERTICES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // random_word [30:0]
    input  logic              s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // vertex [7:0]
    output logic              m_tuser,   // empty_res
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int IW = $clog2(VERTICES);
    localparam logic [IW-1:0] LAST_POS = IW'(VERTICES - 1);
    localparam logic [IW-1:0] PREV_POS = IW'(VERTICES - 2);

    state_t        state_reg;
    state_t        state_next;
    logic [IW-1:0] live_count_reg;
    logic [IW-1:0] fill_cnt_reg;
    logic [7:0]    first_pos_reg;
    logic [7:0]    second_pos_reg;
    logic          exclude_two_reg;
    logic [VW-1:0] a_reg;
    logic [VW-1:0] res_vertex_reg;
    logic          res_empty_reg;
    logic          m_tvalid_reg;
    logic [VW-1:0] m_vertex_reg;
    logic          m_empty_reg;

    logic          in_beat;
    logic          div_start;
    logic          div_done;
    logic [IW-1:0] div_rem;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [VW-1:0] mem_rdata;
    logic          load_out;
    logic [IW-1:0] last_idx;
    logic          src_ok;
    logic          tgt_ok;
    logic [IW-1:0] src_pos;
    logic [IW-1:0] tgt_pos;
    logic [IW-1:0] fill_val;

    // entry after the source exchange on an identity pool
    function automatic logic [IW-1:0] after_src(
        input logic [IW-1:0] j,
        input logic          ok,
        input logic [IW-1:0] s
    );
        logic [IW-1:0] v;
        v = j;
        if (ok && j == s)
        begin
            v = LAST_POS;
        end
        else if (ok && j == LAST_POS)
        begin
            v = s;
        end
        return v;
    endfunction

    assign src_ok   = (32'(first_pos_reg) < VERTICES);
    assign tgt_ok   = (32'(second_pos_reg) < VERTICES);
    assign src_pos  = IW'(first_pos_reg);
    assign tgt_pos  = IW'(second_pos_reg);
    assign last_idx = live_count_reg - 1'b1;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        fill_val = after_src(fill_cnt_reg, src_ok, src_pos);
        if (exclude_two_reg && tgt_ok)
        begin
            if (fill_cnt_reg == tgt_pos)
            begin
                fill_val = after_src(PREV_POS, src_ok, src_pos);
            end
            else if (fill_cnt_reg == PREV_POS)
            begin
                fill_val = after_src(tgt_pos, src_ok, src_pos);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == OP_RESTART)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (live_count_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_FILL:
            begin
                if (fill_cnt_reg == LAST_POS)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_WR_A;
            ST_WR_A: state_next = ST_WR_B;
            ST_WR_B: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = fill_cnt_reg;
        mem_wdata = VW'(fill_val);
        mem_raddr = div_rem;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (s_tuser == OP_DRAW) && (live_count_reg != '0);
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
            end
            ST_DIV:  ;
            ST_RD_A: mem_raddr = div_rem;
            ST_RD_B: mem_raddr = last_idx;
            ST_WR_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = div_rem;
                mem_wdata = mem_rdata;
            end
            ST_WR_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = last_idx;
                mem_wdata = a_reg;
            end
            ST_EMIT:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            live_count_reg  <= '0;
            fill_cnt_reg    <= '0;
            first_pos_reg   <= 8'd0;
            second_pos_reg  <= 8'd1;
            exclude_two_reg <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_FIRST_POS:   first_pos_reg   <= cfg_wdata;
                    CFG_SECOND_POS:  second_pos_reg  <= cfg_wdata;
                    CFG_EXCLUDE_TWO: exclude_two_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && in_beat && s_tuser == OP_RESTART)
            begin
                fill_cnt_reg   <= '0;
                live_count_reg <= exclude_two_reg ? PREV_POS : LAST_POS;
            end
            if (state_reg == ST_FILL)
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (state_reg == ST_WR_B)
            begin
                live_count_reg <= last_idx;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_beat)
        begin
            res_vertex_reg <= '0;
            res_empty_reg  <= 1'b1;
        end
        if (state_reg == ST_RD_B)
        begin
            a_reg <= mem_rdata;
        end
        if (state_reg == ST_WR_B)
        begin
            res_vertex_reg <= a_reg;
            res_empty_reg  <= 1'b0;
        end
        if (load_out)
        begin
            m_vertex_reg <= res_vertex_reg;
            m_empty_reg  <= res_empty_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_vertex_reg;
    assign m_tuser  = m_empty_reg;

    rdwr_rem #(
        .IW (IW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[RW-1:0]),
        .divisor  (live_count_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    rdwr_pool #(
        .DEPTH (VERTICES),
        .AW    (IW)
    ) u_pool (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
